@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the hasher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under an active-low reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sha_pkg.sv @@
// Types and constants of the SHA-256 hasher
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE, S_PAD, S_ZERO, S_LEN, S_CLOAD, S_CRUN, S_CADD, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		RET_IDLE, RET_PAD, RET_ZERO, RET_OUT
	} ret_t;

	typedef struct packed {
		logic       load_byte;
		logic       pad;
		logic       clear_blk;
		logic       put_len;
		logic       comp_load;
		logic       comp_round;
		logic       comp_add;
		logic       reset_msg;
		logic [5:0] round;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/sha_datapath.sv @@
// Datapath: block buffer, message schedule, round logic, hash and length registers
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sha_pkg::dp_cmd_t cmd,
	input  wire logic [7:0]       data_byte,
	input  wire logic [2:0]       word_sel,
	output sha_pkg::dp_stat_t     stat,
	output logic [31:0]           digest_word
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] hash_q [8];
	logic [63:0] cnt_q;

	logic [5:0]  pos;
	logic [31:0] s0, s1, w_new, sig0, sig1, ch, maj, t1, t2;

	assign pos = cnt_q[8:3];
	assign stat.pos = pos;
	assign digest_word = hash_q[word_sel];

	always_comb begin
		s0    = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1    = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		sig1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + sig1 + ch + sha_pkg::ROUND_K[cmd.round] + w_q[0];
		sig0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = sig0 + maj;
	end

	// block buffer doubles as the rolling schedule window
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			for (int j = 0; j < 16; j++) begin
				for (int l = 0; l < 4; l++) begin
					if (pos == 6'(j * 4 + l))
						w_q[j][31 - 8 * l -: 8] <= data_byte;
				end
			end
		end else if (cmd.pad) begin
			for (int j = 0; j < 16; j++) begin
				for (int l = 0; l < 4; l++) begin
					if (pos == 6'(j * 4 + l))
						w_q[j][31 - 8 * l -: 8] <= sha_pkg::PAD_BYTE;
					else if (6'(j * 4 + l) > pos)
						w_q[j][31 - 8 * l -: 8] <= 8'd0;
				end
			end
		end else if (cmd.clear_blk) begin
			for (int j = 0; j < 16; j++)
				w_q[j] <= 32'd0;
		end else if (cmd.put_len) begin
			w_q[14] <= cnt_q[63:32];
			w_q[15] <= cnt_q[31:0];
		end else if (cmd.comp_round) begin
			for (int j = 0; j < 15; j++)
				w_q[j] <= w_q[j + 1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comp_load) begin
			for (int j = 0; j < 8; j++)
				v_q[j] <= hash_q[j];
		end else if (cmd.comp_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++)
				hash_q[j] <= sha_pkg::INIT_HASH[j];
			cnt_q <= 64'd0;
		end else begin
			if (cmd.comp_add) begin
				for (int j = 0; j < 8; j++)
					hash_q[j] <= hash_q[j] + v_q[j];
			end else if (cmd.reset_msg) begin
				for (int j = 0; j < 8; j++)
					hash_q[j] <= sha_pkg::INIT_HASH[j];
			end
			if (cmd.reset_msg)
				cnt_q <= 64'd0;
			else if (cmd.load_byte)
				cnt_q <= cnt_q + 64'd8;
		end
	end

	`ASSERT_NEXT(a_count_step, clk, arst_n, cmd.load_byte && !cmd.reset_msg, cnt_q == $past(cnt_q) + 64'd8, "bit count did not advance by one byte")
	`ASSERT_NEXT(a_count_clear, clk, arst_n, cmd.reset_msg, cnt_q == 64'd0, "bit count not cleared after digest")
	`ASSERT_NEXT(a_hash_reload, clk, arst_n, cmd.reset_msg, hash_q[0] == sha_pkg::INIT_HASH[0], "hash not reloaded after digest")

endmodule
`default_nettype wire

@@ hw/rtl/sha_controller.sv @@
// Controller: sequences byte loading, padding, compression rounds and digest output
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              has_byte,
	input  wire logic              end_of_message,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire sha_pkg::dp_stat_t stat,
	output sha_pkg::dp_cmd_t       cmd,
	output logic [2:0]             word_sel
);

	sha_pkg::state_t state_q, state_d;
	sha_pkg::ret_t   ret_q, ret_d;
	logic [5:0]      round_q, round_d;
	logic [2:0]      idx_q, idx_d;

	assign word_sel = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::S_IDLE;
			ret_q   <= sha_pkg::RET_IDLE;
			round_q <= 6'd0;
			idx_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			round_q <= round_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		round_d   = round_q;
		idx_d     = idx_q;
		cmd       = '0;
		cmd.round = round_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			sha_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (has_byte) begin
						cmd.load_byte = 1'b1;
						if (stat.pos == sha_pkg::LAST_POS) begin
							state_d = sha_pkg::S_CLOAD;
							ret_d   = end_of_message ? sha_pkg::RET_PAD : sha_pkg::RET_IDLE;
						end else if (end_of_message) begin
							state_d = sha_pkg::S_PAD;
						end
					end else if (end_of_message) begin
						state_d = sha_pkg::S_PAD;
					end
				end
			end
			sha_pkg::S_PAD: begin
				cmd.pad = 1'b1;
				// no room for the length: finish this block, then a zero block
				if (stat.pos >= sha_pkg::LEN_POS) begin
					state_d = sha_pkg::S_CLOAD;
					ret_d   = sha_pkg::RET_ZERO;
				end else begin
					state_d = sha_pkg::S_LEN;
				end
			end
			sha_pkg::S_ZERO: begin
				cmd.clear_blk = 1'b1;
				state_d       = sha_pkg::S_LEN;
			end
			sha_pkg::S_LEN: begin
				cmd.put_len = 1'b1;
				state_d     = sha_pkg::S_CLOAD;
				ret_d       = sha_pkg::RET_OUT;
			end
			sha_pkg::S_CLOAD: begin
				cmd.comp_load = 1'b1;
				round_d       = 6'd0;
				state_d       = sha_pkg::S_CRUN;
			end
			sha_pkg::S_CRUN: begin
				cmd.comp_round = 1'b1;
				round_d        = round_q + 6'd1;
				if (round_q == sha_pkg::LAST_ROUND)
					state_d = sha_pkg::S_CADD;
			end
			sha_pkg::S_CADD: begin
				cmd.comp_add = 1'b1;
				idx_d        = 3'd0;
				unique case (ret_q)
					sha_pkg::RET_IDLE: state_d = sha_pkg::S_IDLE;
					sha_pkg::RET_PAD:  state_d = sha_pkg::S_PAD;
					sha_pkg::RET_ZERO: state_d = sha_pkg::S_ZERO;
					sha_pkg::RET_OUT:  state_d = sha_pkg::S_OUT;
					default:           state_d = sha_pkg::S_IDLE;
				endcase
			end
			sha_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == sha_pkg::LAST_WORD) begin
						cmd.reset_msg = 1'b1;
						state_d       = sha_pkg::S_IDLE;
					end
				end
			end
			default: state_d = sha_pkg::S_IDLE;
		endcase
	end

	`ASSERT_IMPLIES(a_out_holds_in, clk, arst_n, out_valid, in_stall, "input taken during digest output")
	`ASSERT_NEXT(a_round_end, clk, arst_n, state_q == sha_pkg::S_CRUN && round_q == sha_pkg::LAST_ROUND, state_q == sha_pkg::S_CADD, "compression did not end after last round")
	`ASSERT_NEXT(a_last_word, clk, arst_n, out_valid && !out_stall && idx_q == sha_pkg::LAST_WORD, state_q == sha_pkg::S_IDLE, "controller not idle after last digest word")

endmodule
`default_nettype wire

@@ hw/rtl/sha256_message_hasher_top.sv @@
// Byte item: taken while idle; the 64th byte of a block starts compression (load, 64 rounds, add).
// End item: pad, length and compression steps; when the padding spills into a second block,
// compression and a zero block come before the length; then 8 digest items, one per cycle unstalled.
// One item at a time; input is stalled during padding, compression and digest output.
// Reset (arst_n low, asynchronous) loads the initial hash values and clears the bit count.
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_hasher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	sha_pkg::dp_cmd_t  cmd;
	sha_pkg::dp_stat_t stat;
	logic [2:0]        word_sel;

	sha_controller u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.stat           (stat),
		.cmd            (cmd),
		.word_sel       (word_sel)
	);

	sha_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.word_sel    (word_sel),
		.stat        (stat),
		.digest_word (digest_word)
	);

	assign word_index = word_sel;
	assign last_word  = (word_sel == sha_pkg::LAST_WORD);

endmodule
`default_nettype wire
